// File: hw/rtl/asc128a_pkg.sv
// ----------------------------------------------------------------------------
// asc128a_pkg
// Types, codes and the permutation round shared by the Ascon-128a engine.
// ----------------------------------------------------------------------------
package asc128a_pkg;

  typedef logic [63:0]  lane_t;
  typedef lane_t [4:0]  lanes_t;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_AD    = 2'd1;
  localparam logic [1:0] CMD_MSG   = 2'd2;
  localparam logic [1:0] CMD_FINAL = 2'd3;

  localparam logic [3:0] LAST_RND  = 4'd11;
  localparam logic [4:0] BLK_BYTES = 5'd16;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_AD   = 4'b0010,
    PH_MSG  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_PERM = 2'b10
  } fsm_t;

  typedef enum logic [3:0] {
    POST_NONE = 4'b0001,
    POST_KEY  = 4'b0010,
    POST_DSEP = 4'b0100,
    POST_TAG  = 4'b1000
  } post_t;

  function automatic lane_t rotr(lane_t x, int n);
    logic [127:0] tmp;
    tmp = {x, x} >> n;
    return tmp[63:0];
  endfunction

  function automatic lanes_t asc_round(lanes_t s, logic [3:0] r);
    lane_t x0, x1, x2, x3, x4;
    lane_t t0, t1, t2, t3, t4;
    x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
    x2 = x2 ^ {56'd0, 4'hf - r, r};
    x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
    t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
    x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
    x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
    x0 = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    x1 = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    x2 = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
    x3 = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    x4 = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
    return {x4, x3, x2, x1, x0};
  endfunction

endpackage

// File: hw/rtl/ascon128a_aead_engine.sv
// ----------------------------------------------------------------------------
// ascon128a_aead_engine
// Ascon-128a AEAD engine: one permutation round per cycle on a shared unit.
// ----------------------------------------------------------------------------
// A start word runs INIT_ROUNDS permutation rounds and an associated-data word
// or a full message word DATA_ROUNDS rounds, one round per cycle in the single
// round unit; a finalize word runs INIT_ROUNDS rounds. A short closing message
// word and a word rejected as out of order give their result in the cycle
// after acceptance. The input side is not ready while rounds run or while a
// result waits that is not being taken in the same cycle. Keys must be written
// through the cfg port only while the engine is idle; it does not enforce this.
module ascon128a_aead_engine
  import asc128a_pkg::*;
#(
  parameter int INIT_ROUNDS = 12,
  parameter int DATA_ROUNDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic        in_decrypt,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  input  logic [4:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic [4:0]  out_count,
  output logic        out_tag_match,
  output logic        out_status
);

  localparam logic [3:0] INIT_START = 4'(12 - INIT_ROUNDS);
  localparam logic [3:0] DATA_START = 4'(12 - DATA_ROUNDS);
  localparam lane_t      IV = {8'd128, 8'd128, 8'(INIT_ROUNDS), 8'(DATA_ROUNDS), 32'd0};

  lane_t        key_high_r, key_low_r;
  lanes_t       lanes_r, lanes_nxt;
  fsm_t         state_r, state_nxt;
  phase_t       phase_r, phase_nxt;
  post_t        post_r, post_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         dec_r, dec_nxt;
  logic         seen_r, seen_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [63:0]  out_high_r, out_high_nxt, out_low_r, out_low_nxt;
  logic [4:0]   out_count_r, out_count_nxt;
  logic         match_r, match_nxt, status_r, status_nxt;

  logic         accept;
  logic [4:0]   nbytes;
  logic [127:0] blk, din, msk, pad, blk_new;
  lanes_t       rnd_out;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign nbytes   = (in_byte_count > BLK_BYTES) ? BLK_BYTES : in_byte_count;
  assign blk      = {lanes_r[0], lanes_r[1]};
  assign din      = {in_data_high, in_data_low};
  assign msk      = (nbytes == 5'd0) ? 128'd0
                  : ~128'd0 << 8'({3'd0, BLK_BYTES - nbytes} << 3);
  assign pad      = 128'h80 << 8'({3'd0, 5'd15 - nbytes} << 3);
  assign rnd_out  = asc_round(lanes_r, rnd_r);

  always_comb begin
    lanes_nxt     = lanes_r;
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    post_nxt      = post_r;
    rnd_nxt       = rnd_r;
    dec_nxt       = dec_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_high_nxt  = out_high_r;
    out_low_nxt   = out_low_r;
    out_count_nxt = out_count_r;
    match_nxt     = match_r;
    status_nxt    = status_r;
    blk_new       = blk;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_high_nxt  = '0;
          out_low_nxt   = '0;
          out_count_nxt = '0;
          match_nxt     = 1'b0;
          status_nxt    = 1'b0;
          unique case (in_cmd)
            CMD_START: begin
              lanes_nxt = {in_data_low, in_data_high, key_low_r, key_high_r, IV};
              rnd_nxt   = INIT_START;
              post_nxt  = POST_KEY;
              state_nxt = ST_PERM;
              dec_nxt   = in_decrypt;
              seen_nxt  = 1'b0;
              phase_nxt = PH_AD;
            end
            CMD_AD: begin
              if (phase_r != PH_AD) begin
                status_nxt    = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                blk_new   = blk ^ (din & msk);
                rnd_nxt   = DATA_START;
                state_nxt = ST_PERM;
                if (nbytes == BLK_BYTES) begin
                  seen_nxt = 1'b1;
                  post_nxt = POST_NONE;
                end else begin
                  blk_new   = blk_new ^ pad;
                  seen_nxt  = 1'b0;
                  post_nxt  = POST_DSEP;
                  phase_nxt = PH_MSG;
                end
                lanes_nxt[0] = blk_new[127:64];
                lanes_nxt[1] = blk_new[63:0];
              end
            end
            CMD_MSG: begin
              if (phase_r != PH_MSG && !(phase_r == PH_AD && !seen_r)) begin
                status_nxt    = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                if (phase_r == PH_AD) begin
                  lanes_nxt[4] = lanes_r[4] ^ 64'd1;
                end
                if (dec_r) begin
                  {out_high_nxt, out_low_nxt} = (blk ^ din) & msk;
                  blk_new = (blk & ~msk) | (din & msk);
                end else begin
                  blk_new = blk ^ (din & msk);
                  {out_high_nxt, out_low_nxt} = blk_new & msk;
                end
                out_count_nxt = nbytes;
                if (nbytes == BLK_BYTES) begin
                  rnd_nxt   = DATA_START;
                  post_nxt  = POST_NONE;
                  state_nxt = ST_PERM;
                  phase_nxt = PH_MSG;
                end else begin
                  blk_new       = blk_new ^ pad;
                  phase_nxt     = PH_DONE;
                  out_valid_nxt = 1'b1;
                end
                lanes_nxt[0] = blk_new[127:64];
                lanes_nxt[1] = blk_new[63:0];
              end
            end
            CMD_FINAL: begin
              if (phase_r != PH_DONE) begin
                status_nxt    = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                lanes_nxt[2] = lanes_r[2] ^ key_high_r;
                lanes_nxt[3] = lanes_r[3] ^ key_low_r;
                out_high_nxt = in_data_high;
                out_low_nxt  = in_data_low;
                rnd_nxt      = INIT_START;
                post_nxt     = POST_TAG;
                state_nxt    = ST_PERM;
                phase_nxt    = PH_IDLE;
              end
            end
            default: begin
              status_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_PERM: begin
        lanes_nxt = rnd_out;
        rnd_nxt   = rnd_r + 4'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          case (post_r)
            POST_KEY: begin
              lanes_nxt[3] = rnd_out[3] ^ key_high_r;
              lanes_nxt[4] = rnd_out[4] ^ key_low_r;
            end
            POST_DSEP: begin
              lanes_nxt[4] = rnd_out[4] ^ 64'd1;
            end
            POST_TAG: begin
              lanes_nxt[3]  = rnd_out[3] ^ key_high_r;
              lanes_nxt[4]  = rnd_out[4] ^ key_low_r;
              out_high_nxt  = lanes_nxt[3];
              out_low_nxt   = lanes_nxt[4];
              out_count_nxt = BLK_BYTES;
              match_nxt     = dec_r && (out_high_r == lanes_nxt[3])
                                    && (out_low_r == lanes_nxt[4]);
            end
            default: begin
              lanes_nxt = rnd_out;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r  <= '0;
      key_low_r   <= '0;
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      post_r      <= POST_NONE;
      rnd_r       <= '0;
      dec_r       <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) key_low_r  <= cfg_data;
        else           key_high_r <= cfg_data;
      end
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      post_r      <= post_nxt;
      rnd_r       <= rnd_nxt;
      dec_r       <= dec_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r     <= lanes_nxt;
    out_high_r  <= out_high_nxt;
    out_low_r   <= out_low_nxt;
    out_count_r <= out_count_nxt;
    match_r     <= match_nxt;
    status_r    <= status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_high      = out_high_r;
  assign out_low       = out_low_r;
  assign out_count     = out_count_r;
  assign out_tag_match = match_r;
  assign out_status    = status_r;

  a_no_result_in_perm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PERM) |-> !out_valid_r)
    else $error("result shown while rounds still run");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PERM) |-> (rnd_r <= LAST_RND))
    else $error("round counter past last round");

  a_last_round_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PERM && rnd_r == LAST_RND) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("no result after last round");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |-> (out_count_r == 5'd0 && !match_r
                                   && out_high_r == 64'd0 && out_low_r == 64'd0))
    else $error("rejected word carries data");

  a_match_is_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && match_r) |-> (out_count_r == BLK_BYTES && dec_r && !status_r))
    else $error("tag match outside decrypting finalize");

endmodule

// File: test/ascon128a_aead_engine_tb.sv
// ----------------------------------------------------------------------------
// ascon128a_aead_engine_tb
// Self-checking bench for the Ascon-128a AEAD engine. A cycle-free model of
// the permutation and the start, associated-data, message and finalize
// phases runs beside the engine. Every result word is compared with the model.
// Stimulus is directed command-order and phase cases, then random messages
// under several keys with random gaps and output stalls.
// ----------------------------------------------------------------------------
module ascon128a_aead_engine_tb;
  import asc128a_pkg::*;

  localparam logic  KEY_HIGH_REG = 1'b0;
  localparam logic  KEY_LOW_REG  = 1'b1;
  localparam int    INIT_ROUNDS  = 12;
  localparam int    DATA_ROUNDS  = 8;
  localparam lane_t ONES         = {64{1'b1}};

  typedef struct packed {
    lane_t      hi;
    lane_t      lo;
    logic [4:0] count;
    logic       tag_ok;
    logic       rejected;
  } cipher_reply_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic        in_decrypt;
  logic [63:0] in_data_high;
  logic [63:0] in_data_low;
  logic [4:0]  in_byte_count;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic [4:0]  out_count;
  logic        out_tag_match;
  logic        out_status;

  lanes_t        state_lanes;
  phase_t        state_phase;
  logic          state_decrypt;
  logic          ad_block_open;
  lane_t         key_hi_reg;
  lane_t         key_lo_reg;
  cipher_reply_t cipher_replies [$];
  cipher_reply_t reply_head;

  int idle_pct;
  int stall_pct;
  int mismatches;
  int words_sent;
  int rejected_words;
  int matched_tags;
  int result_words;
  int words_by_cmd [4];

  ascon128a_aead_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_decrypt   (in_decrypt),
    .in_data_high (in_data_high),
    .in_data_low  (in_data_low),
    .in_byte_count(in_byte_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_high     (out_high),
    .out_low      (out_low),
    .out_count    (out_count),
    .out_tag_match(out_tag_match),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("ascon128a_aead_engine test failed");
    $finish;
  end

  function automatic lane_t ror(lane_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic lanes_t permute(lanes_t s, int rounds);
    lane_t      x [5];
    lane_t      t [5];
    int         r;
    int         i;
    logic [3:0] rc;
    for (i = 0; i < 5; i++) x[i] = s[i];
    for (r = 12 - rounds; r < 12; r++) begin
      rc = r[3:0];
      x[2] ^= {56'h0, ~rc, rc};
      x[0] ^= x[4];
      x[4] ^= x[3];
      x[2] ^= x[1];
      for (i = 0; i < 5; i++) t[i] = ~x[i] & x[(i + 1) % 5];
      for (i = 0; i < 5; i++) x[i] ^= t[(i + 1) % 5];
      x[1] ^= x[0];
      x[0] ^= x[4];
      x[3] ^= x[2];
      x[2] = ~x[2];
      x[0] ^= ror(x[0], 19) ^ ror(x[0], 28);
      x[1] ^= ror(x[1], 61) ^ ror(x[1], 39);
      x[2] ^= ror(x[2], 1) ^ ror(x[2], 6);
      x[3] ^= ror(x[3], 10) ^ ror(x[3], 17);
      x[4] ^= ror(x[4], 7) ^ ror(x[4], 41);
    end
    for (i = 0; i < 5; i++) s[i] = x[i];
    return s;
  endfunction

  function automatic lane_t head_mask(int nbytes);
    if (nbytes == 0) return '0;
    if (nbytes >= 8) return ONES;
    return ONES << (8 * (8 - nbytes));
  endfunction

  function automatic lanes_t pad_block(lanes_t s, int nbytes);
    if (nbytes < 8) s[0] ^= 64'h80 << (8 * (7 - nbytes));
    else s[1] ^= 64'h80 << (8 * (15 - nbytes));
    return s;
  endfunction

  function automatic logic [127:0] finalized_tag();
    lanes_t s;
    s = state_lanes;
    s[2] ^= key_hi_reg;
    s[3] ^= key_lo_reg;
    s = permute(s, INIT_ROUNDS);
    return {s[3] ^ key_hi_reg, s[4] ^ key_lo_reg};
  endfunction

  function automatic cipher_reply_t cipher_word(logic [1:0] cmd, logic dec, lane_t dh,
                                                lane_t dl, logic [4:0] nb);
    cipher_reply_t rep;
    int            n;
    lane_t         m0;
    lane_t         m1;
    logic [127:0]  tag;
    rep = '0;
    n = (nb > BLK_BYTES) ? 16 : int'(nb);
    m0 = head_mask(n);
    m1 = head_mask(n > 8 ? n - 8 : 0);
    case (cmd)
      CMD_START: begin
        state_lanes[0] = {8'h80, 8'h80, 8'(INIT_ROUNDS), 8'(DATA_ROUNDS), 32'h0};
        state_lanes[1] = key_hi_reg;
        state_lanes[2] = key_lo_reg;
        state_lanes[3] = dh;
        state_lanes[4] = dl;
        state_lanes = permute(state_lanes, INIT_ROUNDS);
        state_lanes[3] ^= key_hi_reg;
        state_lanes[4] ^= key_lo_reg;
        state_decrypt = dec;
        ad_block_open = 1'b0;
        state_phase = PH_AD;
      end
      CMD_AD: begin
        if (state_phase != PH_AD) begin
          rep.rejected = 1'b1;
        end else begin
          state_lanes[0] ^= dh & m0;
          state_lanes[1] ^= dl & m1;
          if (n == 16) begin
            ad_block_open = 1'b1;
            state_lanes = permute(state_lanes, DATA_ROUNDS);
          end else begin
            state_lanes = pad_block(state_lanes, n);
            state_lanes = permute(state_lanes, DATA_ROUNDS);
            state_lanes[4] ^= 64'h1;
            ad_block_open = 1'b0;
            state_phase = PH_MSG;
          end
        end
      end
      CMD_MSG: begin
        if (state_phase == PH_AD && !ad_block_open) begin
          state_lanes[4] ^= 64'h1;
          state_phase = PH_MSG;
        end
        if (state_phase != PH_MSG) begin
          rep.rejected = 1'b1;
        end else begin
          if (state_decrypt) begin
            rep.hi = (state_lanes[0] ^ dh) & m0;
            rep.lo = (state_lanes[1] ^ dl) & m1;
            state_lanes[0] = (state_lanes[0] & ~m0) | (dh & m0);
            state_lanes[1] = (state_lanes[1] & ~m1) | (dl & m1);
          end else begin
            state_lanes[0] ^= dh & m0;
            state_lanes[1] ^= dl & m1;
            rep.hi = state_lanes[0] & m0;
            rep.lo = state_lanes[1] & m1;
          end
          rep.count = n[4:0];
          if (n == 16) begin
            state_lanes = permute(state_lanes, DATA_ROUNDS);
          end else begin
            state_lanes = pad_block(state_lanes, n);
            state_phase = PH_DONE;
          end
        end
      end
      CMD_FINAL: begin
        if (state_phase != PH_DONE) begin
          rep.rejected = 1'b1;
        end else begin
          tag = finalized_tag();
          rep.hi = tag[127:64];
          rep.lo = tag[63:0];
          rep.count = BLK_BYTES;
          rep.tag_ok = state_decrypt && (tag == {dh, dl});
          state_phase = PH_IDLE;
        end
      end
    endcase
    return rep;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s expected %h got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      result_words++;
      if (cipher_replies.size() == 0) begin
        $error("result word with nothing pending");
        mismatches++;
      end else begin
        reply_head = cipher_replies.pop_front();
        compare_field("out_high", reply_head.hi, out_high);
        compare_field("out_low", reply_head.lo, out_low);
        compare_field("out_count", 64'(reply_head.count), 64'(out_count));
        compare_field("out_tag_match", 64'(reply_head.tag_ok), 64'(out_tag_match));
        compare_field("out_status", 64'(reply_head.rejected), 64'(out_status));
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic lane_t rand_lane();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [4:0] full_count();
    return ($urandom_range(7) == 0) ? 5'($urandom_range(31, 17)) : BLK_BYTES;
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic dec, input lane_t dh,
                           input lane_t dl, input logic [4:0] nb);
    cipher_reply_t rep;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_decrypt    <= dec;
    in_data_high  <= dh;
    in_data_low   <= dl;
    in_byte_count <= nb;
    do @(posedge clk); while (!in_ready);
    rep = cipher_word(cmd, dec, dh, dl, nb);
    cipher_replies.push_back(rep);
    words_sent++;
    words_by_cmd[cmd]++;
    if (rep.rejected) rejected_words++;
    if (rep.tag_ok) matched_tags++;
  endtask

  task automatic wait_engine_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cipher_replies.size() != 0) @(negedge clk);
  endtask

  task automatic load_key(input lane_t hi, input lane_t lo);
    wait_engine_idle();
    cfg_we    <= 1'b1;
    cfg_index <= KEY_HIGH_REG;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_index <= KEY_LOW_REG;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_we <= 1'b0;
    key_hi_reg = hi;
    key_lo_reg = lo;
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99) < 6)
      send_word(2'($urandom_range(3)), 1'($urandom_range(1)), rand_lane(), rand_lane(),
                5'($urandom_range(31)));
  endtask

  task automatic send_message();
    logic         dec;
    int           n_ad;
    int           n_msg;
    int           i;
    logic [127:0] tag;
    dec = 1'($urandom_range(1));
    send_word(CMD_START, dec, rand_lane(), rand_lane(), 5'($urandom_range(31)));
    maybe_noise();
    if ($urandom_range(3) != 0) begin
      n_ad = $urandom_range(3);
      for (i = 0; i < n_ad; i++) begin
        send_word(CMD_AD, 1'($urandom_range(1)), rand_lane(), rand_lane(), full_count());
        maybe_noise();
      end
      send_word(CMD_AD, 1'($urandom_range(1)), rand_lane(), rand_lane(),
                5'($urandom_range(15)));
      maybe_noise();
    end
    n_msg = $urandom_range(3);
    for (i = 0; i < n_msg; i++) begin
      send_word(CMD_MSG, 1'($urandom_range(1)), rand_lane(), rand_lane(), full_count());
      maybe_noise();
    end
    send_word(CMD_MSG, 1'($urandom_range(1)), rand_lane(), rand_lane(),
              5'($urandom_range(15)));
    maybe_noise();
    tag = finalized_tag();
    if (!dec) tag = {rand_lane(), rand_lane()};
    else if ($urandom_range(1) == 0) tag ^= 128'h1 << $urandom_range(127);
    send_word(CMD_FINAL, 1'($urandom_range(1)), tag[127:64], tag[63:0],
              5'($urandom_range(31)));
    maybe_noise();
  endtask

  task automatic test_out_of_order();
    send_word(CMD_AD, 1'b1, ONES, ONES, 5'd16);
    send_word(CMD_MSG, 1'b0, ONES, ONES, 5'd4);
    send_word(CMD_FINAL, 1'b1, '0, '0, 5'd0);
  endtask

  task automatic test_encrypt_flow();
    send_word(CMD_START, 1'b0, ONES, ONES, 5'd0);
    send_word(CMD_AD, 1'b0, ONES, ONES, 5'd16);
    send_word(CMD_MSG, 1'b0, ONES, ONES, 5'd16);
    send_word(CMD_FINAL, 1'b0, ONES, ONES, 5'd16);
    send_word(CMD_AD, 1'b0, ONES, ONES, 5'd0);
    send_word(CMD_AD, 1'b0, ONES, ONES, 5'd8);
    send_word(CMD_FINAL, 1'b0, ONES, ONES, 5'd16);
    send_word(CMD_MSG, 1'b0, ONES, '0, 5'd31);
    send_word(CMD_MSG, 1'b1, '0, ONES, 5'd15);
    send_word(CMD_MSG, 1'b0, ONES, ONES, 5'd16);
    send_word(CMD_FINAL, 1'b0, '0, '0, 5'd0);
  endtask

  task automatic test_decrypt_flow();
    logic [127:0] tag;
    send_word(CMD_START, 1'b1, '0, '0, 5'd16);
    send_word(CMD_MSG, 1'b1, ONES, ONES, 5'd16);
    send_word(CMD_MSG, 1'b0, ONES, ONES, 5'd0);
    tag = finalized_tag();
    send_word(CMD_FINAL, 1'b1, tag[127:64], tag[63:0], 5'd16);
  endtask

  task automatic test_restart();
    logic [127:0] tag;
    send_word(CMD_START, 1'b0, ONES, '0, 5'd0);
    send_word(CMD_AD, 1'b0, ONES, ONES, 5'd16);
    send_word(CMD_START, 1'b1, '0, ONES, 5'd0);
    send_word(CMD_MSG, 1'b1, ONES, '0, 5'd16);
    send_word(CMD_START, 1'b1, ONES, ONES, 5'd31);
    send_word(CMD_AD, 1'b0, ONES, ONES, 5'd8);
    send_word(CMD_MSG, 1'b1, ONES, ONES, 5'd9);
    tag = finalized_tag() ^ 128'h1;
    send_word(CMD_FINAL, 1'b1, tag[127:64], tag[63:0], 5'd16);
  endtask

  task automatic test_random_traffic(input int words, input int idle);
    int stop;
    stop = words_sent + words;
    idle_pct = idle;
    stall_pct = idle;
    while (words_sent < stop) send_message();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = KEY_HIGH_REG;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_cmd        = CMD_START;
    in_decrypt    = 1'b0;
    in_data_high  = '0;
    in_data_low   = '0;
    in_byte_count = '0;
    out_ready     = 1'b0;
    idle_pct      = 35;
    stall_pct     = 35;
    state_lanes   = '0;
    state_phase   = PH_IDLE;
    state_decrypt = 1'b0;
    ad_block_open = 1'b0;
    key_hi_reg    = '0;
    key_lo_reg    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_key('0, '0);
    test_out_of_order();
    test_encrypt_flow();
    load_key(ONES, ONES);
    test_decrypt_flow();
    test_restart();
    load_key('0, ONES);
    test_random_traffic(260, 35);
    load_key(ONES, '0);
    test_random_traffic(260, 35);
    load_key(rand_lane(), rand_lane());
    test_random_traffic(260, 0);
    load_key(rand_lane(), rand_lane());
    test_random_traffic(260, 35);
    load_key(rand_lane(), rand_lane());
    test_random_traffic(260, 35);

    wait_engine_idle();
    repeat (40) @(posedge clk);
    $display("Sent %0d words: %0d start, %0d ad, %0d msg, %0d final; %0d results checked",
             words_sent, words_by_cmd[CMD_START], words_by_cmd[CMD_AD],
             words_by_cmd[CMD_MSG], words_by_cmd[CMD_FINAL], result_words);
    $display("%0d words rejected as out of order, %0d decrypt tags matched, 7 keys used",
             rejected_words, matched_tags);
    if (mismatches == 0)
      $display("ascon128a_aead_engine test passed");
    else
      $display("ascon128a_aead_engine test failed");
    $finish;
  end

endmodule
